// ===== rtl/flat_json_object_parser_core_defines.svh =====
// Assertion macros shared by the flat JSON object parser RTL.
`ifndef FLAT_JSON_OBJECT_PARSER_CORE_DEFINES_SVH
`define FLAT_JSON_OBJECT_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FJP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define FJP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/fjp_pkg.sv =====
// Types, constants and the byte classifier of the flat JSON object parser.
`default_nettype none
package fjp_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int MID_DEPTH_DEF     = 2;
  localparam int OUT_DEPTH_DEF     = 2;
  localparam int ERR_POS_W         = 16;
  localparam int SKIP_W            = 3;

  localparam logic [SKIP_W-1:0] HEX_SKIP    = 3'd4;
  localparam logic [SKIP_W-1:0] BOOL_T_SKIP = 3'd3;
  localparam logic [SKIP_W-1:0] BOOL_F_SKIP = 3'd4;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_LOWER_E = 8'h65;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_R = 8'h72;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_LOWER_U = 8'h75;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_KEY_CHAR  = 3'd1,
    EV_KEY_END   = 3'd2,
    EV_STR_CHAR  = 3'd3,
    EV_NUM_CHAR  = 3'd4,
    EV_VALUE_END = 3'd5,
    EV_BOOL      = 3'd6,
    EV_ACCEPTED  = 3'd7
  } event_kind_t;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_BRACE     = 4'd1,
    ERR_QUOTE     = 4'd2,
    ERR_ESCAPE    = 4'd3,
    ERR_NUL       = 4'd4,
    ERR_VALUE     = 4'd5,
    ERR_NUMBER    = 4'd6,
    ERR_COMMA     = 4'd7,
    ERR_COLON     = 4'd8,
    ERR_EARLY_END = 4'd9,
    ERR_TRAILING  = 4'd10
  } err_t;

  typedef enum logic [4:0] {
    PH_OPEN, PH_MEMBER, PH_KEY_START,
    PH_KEY_FIRST, PH_KEY_REST, PH_KEY_ESC, PH_KEY_HEX,
    PH_COLON, PH_VALUE,
    PH_STR_FIRST, PH_STR_REST, PH_STR_ESC, PH_STR_HEX,
    PH_NUM_SIGN, PH_NUM_ZERO, PH_NUM_INT, PH_NUM_DOT, PH_NUM_FRAC,
    PH_NUM_EXP, PH_NUM_EXPSIGN, PH_NUM_EXPDIG,
    PH_BOOL_T, PH_BOOL_F, PH_DONE, PH_ERROR
  } phase_t;

  typedef enum logic [4:0] {
    CC_OTHER, CC_WS, CC_LBRACE, CC_RBRACE, CC_COMMA, CC_COLON, CC_QUOTE,
    CC_BSLASH, CC_MINUS, CC_PLUS, CC_ZERO, CC_DIGIT, CC_DOT, CC_EXP,
    CC_T, CC_F, CC_NUL
  } cls_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    event_kind_t          event_kind;
    logic [7:0]           out_char;
    logic                 bool_value;
    logic                 value_closed;
    err_t                 error_code;
    logic [ERR_POS_W-1:0] error_position;
  } out_item_t;

  typedef struct packed {
    cls_t       cls;
    logic [7:0] ch;
    logic       eot;
    logic       esc_ok;
    logic       esc_u;
    logic [7:0] esc_char;
  } tok_t;

  function automatic tok_t classify(input in_item_t item);
    tok_t t;
    t.ch       = item.in_byte;
    t.eot      = item.end_of_text;
    t.esc_ok   = 1'b1;
    t.esc_u    = 1'b0;
    t.esc_char = item.in_byte;
    unique case (item.in_byte) inside
      CH_SPACE, [CH_TAB:CH_CR]: t.cls = CC_WS;
      CH_LBRACE:                t.cls = CC_LBRACE;
      CH_RBRACE:                t.cls = CC_RBRACE;
      CH_COMMA:                 t.cls = CC_COMMA;
      CH_COLON:                 t.cls = CC_COLON;
      CH_QUOTE:                 t.cls = CC_QUOTE;
      CH_BSLASH:                t.cls = CC_BSLASH;
      CH_MINUS:                 t.cls = CC_MINUS;
      CH_PLUS:                  t.cls = CC_PLUS;
      CH_ZERO:                  t.cls = CC_ZERO;
      [8'h31:8'h39]:            t.cls = CC_DIGIT;
      CH_DOT:                   t.cls = CC_DOT;
      CH_LOWER_E, CH_UPPER_E:   t.cls = CC_EXP;
      CH_LOWER_T:               t.cls = CC_T;
      CH_LOWER_F:               t.cls = CC_F;
      CH_NUL:                   t.cls = CC_NUL;
      default:                  t.cls = CC_OTHER;
    endcase
    unique case (item.in_byte) inside
      CH_QUOTE, CH_BSLASH, CH_SLASH: t.esc_char = item.in_byte;
      CH_LOWER_B: t.esc_char = CH_BS;
      CH_LOWER_F: t.esc_char = CH_FF;
      CH_LOWER_N: t.esc_char = CH_LF;
      CH_LOWER_R: t.esc_char = CH_CR;
      CH_LOWER_T: t.esc_char = CH_TAB;
      CH_LOWER_U: t.esc_u    = 1'b1;
      default:    t.esc_ok   = 1'b0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/flat_json_object_parser_core.sv =====
// Top level of the flat JSON object parser: front, token queue, back, result queue.
`default_nettype none
// One text byte per beat in, one result beat out per byte. Sustained rate is one
// byte per clock while neither side stalls; a byte's result goes through the front
// register and the token queue, then the back stage writes it into the result queue,
// from which it can be popped. The rate is set by the back stage, whose phase, skip
// count and position update are computed combinationally from each token.
// Both queues let either side stall without losing beats;
// full rises only when the front register and the token queue are both occupied.
// Error positions count from zero per text and wrap at 2**POSITION_BITS.
module flat_json_object_parser_core
  import fjp_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int MID_DEPTH     = MID_DEPTH_DEF,
  parameter int OUT_DEPTH     = OUT_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire in_item_t in_data,
  output logic          full,
  output logic          empty,
  input  wire logic     pop,
  output out_item_t     out_data
);

  localparam int TOK_W = $bits(tok_t);
  localparam int RES_W = $bits(out_item_t);

  tok_t             front_tok, back_tok;
  logic             front_valid, mid_full, mid_empty, mid_pop;
  logic [TOK_W-1:0] mid_rd;
  out_item_t        back_res;
  logic             res_push, res_full;
  logic [RES_W-1:0] out_rd;

  assign back_tok = tok_t'(mid_rd);
  assign out_data = out_item_t'(out_rd);

  fjp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .full      (full),
    .tok       (front_tok),
    .tok_valid (front_valid),
    .mid_full  (mid_full)
  );

  fjp_fifo #(
    .WIDTH (TOK_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (front_valid),
    .wr_data (front_tok),
    .full    (mid_full),
    .rd_en   (mid_pop),
    .rd_data (mid_rd),
    .empty   (mid_empty)
  );

  fjp_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok       (back_tok),
    .tok_empty (mid_empty),
    .tok_pop   (mid_pop),
    .res       (back_res),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  fjp_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (back_res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_rd),
    .empty   (empty)
  );

endmodule
`default_nettype wire

// ===== rtl/fjp_fifo.sv =====
// Small register queue with first-word fall-through read.
`default_nettype none
module fjp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fjp_front.sv =====
// Front stage: takes text beats, classifies each byte and registers the token.
`default_nettype none
module fjp_front
  import fjp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire in_item_t in_data,
  output logic          full,
  output tok_t          tok,
  output logic          tok_valid,
  input  wire logic     mid_full
);

  tok_t tok_r;
  logic valid_r, valid_nxt;
  logic take;

  assign take      = push && !full;
  assign full      = valid_r && mid_full;
  assign tok       = tok_r;
  assign tok_valid = valid_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (!mid_full) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tok_r <= classify(in_data);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fjp_back.sv =====
// Back stage: phase machine that turns classified tokens into result beats.
`default_nettype none
`include "flat_json_object_parser_core_defines.svh"
module fjp_back
  import fjp_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire tok_t tok,
  input  wire logic tok_empty,
  output logic      tok_pop,
  output out_item_t res,
  output logic      res_push,
  input  wire logic res_full
);

  phase_t                   ph_r, ph_nxt, ph_main;
  logic [SKIP_W-1:0]        skip_r, skip_nxt;
  logic                     pair_r, pair_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, pos_inc;
  logic [POSITION_BITS+ERR_POS_W-1:0] pos_ext, inc_ext;
  logic step, go, close, dig, is_key, s_rest, s_esc, s_hex, is_num;
  event_kind_t chr_kind;

  assign step     = !tok_empty && !res_full;
  assign tok_pop  = step;
  assign res_push = step;
  assign pos_inc  = pos_r + 1'b1;
  assign pos_ext  = {{ERR_POS_W{1'b0}}, pos_r};
  assign inc_ext  = {{ERR_POS_W{1'b0}}, pos_inc};

  assign dig      = (tok.cls == CC_ZERO) || (tok.cls == CC_DIGIT);
  assign is_key   = ph_r inside {PH_KEY_FIRST, PH_KEY_REST, PH_KEY_ESC, PH_KEY_HEX};
  assign s_rest   = (ph_r == PH_KEY_REST) || (ph_r == PH_STR_REST);
  assign s_esc    = (ph_r == PH_KEY_ESC) || (ph_r == PH_STR_ESC);
  assign s_hex    = (ph_r == PH_KEY_HEX) || (ph_r == PH_STR_HEX);
  assign is_num   = (ph_r >= PH_NUM_SIGN) && (ph_r <= PH_NUM_EXPDIG);
  assign chr_kind = is_key ? EV_KEY_CHAR : EV_STR_CHAR;

  always_comb begin
    ph_nxt   = ph_r;
    skip_nxt = skip_r;
    pair_nxt = pair_r;
    ph_main  = ph_r;
    res      = '0;
    go       = 1'b1;
    close    = 1'b0;

    if (ph_r != PH_ERROR) begin
      if (is_num) begin
        go = 1'b0;
        unique case (ph_r)
          PH_NUM_SIGN: begin
            if (dig) begin
              res.event_kind = EV_NUM_CHAR;
              res.out_char   = tok.ch;
              ph_nxt = (tok.cls == CC_ZERO) ? PH_NUM_ZERO : PH_NUM_INT;
            end else begin
              res.error_code = ERR_NUMBER;
              ph_nxt = PH_ERROR;
            end
          end
          PH_NUM_ZERO, PH_NUM_INT, PH_NUM_FRAC: begin
            if (dig && ph_r != PH_NUM_ZERO) begin
              res.event_kind = EV_NUM_CHAR;
              res.out_char   = tok.ch;
              if (ph_r == PH_NUM_FRAC) begin
                ph_nxt = PH_NUM_FRAC;
              end
            end else if (tok.cls == CC_DOT && ph_r != PH_NUM_FRAC) begin
              res.event_kind = EV_NUM_CHAR;
              res.out_char   = tok.ch;
              ph_nxt = PH_NUM_DOT;
            end else if (tok.cls == CC_EXP) begin
              res.event_kind = EV_NUM_CHAR;
              res.out_char   = tok.ch;
              ph_nxt = PH_NUM_EXP;
            end else begin
              close = 1'b1;
            end
          end
          PH_NUM_DOT, PH_NUM_EXPSIGN: begin
            if (dig) begin
              res.event_kind = EV_NUM_CHAR;
              res.out_char   = tok.ch;
              ph_nxt = (ph_r == PH_NUM_DOT) ? PH_NUM_FRAC : PH_NUM_EXPDIG;
            end else begin
              res.error_code = ERR_NUMBER;
              ph_nxt = PH_ERROR;
            end
          end
          PH_NUM_EXP: begin
            if (tok.cls == CC_PLUS || tok.cls == CC_MINUS) begin
              res.event_kind = EV_NUM_CHAR;
              res.out_char   = tok.ch;
              ph_nxt = PH_NUM_EXPSIGN;
            end else if (dig) begin
              res.event_kind = EV_NUM_CHAR;
              res.out_char   = tok.ch;
              ph_nxt = PH_NUM_EXPDIG;
            end else begin
              res.error_code = ERR_NUMBER;
              ph_nxt = PH_ERROR;
            end
          end
          default: begin
            if (dig) begin
              res.event_kind = EV_NUM_CHAR;
              res.out_char   = tok.ch;
            end else begin
              close = 1'b1;
            end
          end
        endcase
        if (close) begin
          res.value_closed = 1'b1;
          ph_main  = PH_MEMBER;
          ph_nxt   = PH_MEMBER;
          pair_nxt = 1'b1;
          go       = 1'b1;
        end
      end

      if (go) begin
        unique case (ph_main) inside
          PH_KEY_FIRST, PH_KEY_REST, PH_KEY_ESC, PH_KEY_HEX,
          PH_STR_FIRST, PH_STR_REST, PH_STR_ESC, PH_STR_HEX: begin
            if (s_hex) begin
              if (skip_r > 3'd1) begin
                skip_nxt = skip_r - 1'b1;
              end else begin
                skip_nxt = '0;
                ph_nxt   = is_key ? PH_KEY_REST : PH_STR_REST;
              end
            end else if (s_esc) begin
              if (tok.esc_u) begin
                skip_nxt = HEX_SKIP;
                ph_nxt   = is_key ? PH_KEY_HEX : PH_STR_HEX;
              end else if (tok.esc_ok) begin
                res.event_kind = chr_kind;
                res.out_char   = tok.esc_char;
                ph_nxt = is_key ? PH_KEY_REST : PH_STR_REST;
              end else begin
                res.error_code = ERR_ESCAPE;
                ph_nxt = PH_ERROR;
              end
            end else if (s_rest && tok.cls == CC_NUL) begin
              res.error_code = ERR_NUL;
              ph_nxt = PH_ERROR;
            end else if (tok.cls == CC_QUOTE) begin
              if (is_key) begin
                res.event_kind = EV_KEY_END;
                ph_nxt = PH_COLON;
              end else begin
                res.event_kind = EV_VALUE_END;
                ph_nxt   = PH_MEMBER;
                pair_nxt = 1'b1;
              end
            end else if (tok.cls == CC_BSLASH) begin
              ph_nxt = is_key ? PH_KEY_ESC : PH_STR_ESC;
            end else begin
              res.event_kind = chr_kind;
              res.out_char   = tok.ch;
              ph_nxt = is_key ? PH_KEY_REST : PH_STR_REST;
            end
          end
          PH_OPEN: begin
            if (tok.cls == CC_LBRACE) begin
              ph_nxt   = PH_MEMBER;
              pair_nxt = 1'b0;
            end else if (tok.cls != CC_WS) begin
              res.error_code = ERR_BRACE;
              ph_nxt = PH_ERROR;
            end
          end
          PH_MEMBER: begin
            if (tok.cls == CC_WS) begin
              ph_nxt = PH_MEMBER;
            end else if (tok.cls == CC_RBRACE) begin
              ph_nxt = PH_DONE;
            end else if (pair_nxt) begin
              if (tok.cls == CC_COMMA) begin
                ph_nxt = PH_KEY_START;
              end else begin
                res.error_code = ERR_COMMA;
                ph_nxt = PH_ERROR;
              end
            end else if (tok.cls == CC_QUOTE) begin
              ph_nxt = PH_KEY_FIRST;
            end else begin
              res.error_code = ERR_QUOTE;
              ph_nxt = PH_ERROR;
            end
          end
          PH_KEY_START: begin
            if (tok.cls == CC_QUOTE) begin
              ph_nxt = PH_KEY_FIRST;
            end else if (tok.cls != CC_WS) begin
              res.error_code = ERR_QUOTE;
              ph_nxt = PH_ERROR;
            end
          end
          PH_COLON: begin
            if (tok.cls == CC_COLON) begin
              ph_nxt = PH_VALUE;
            end else if (tok.cls != CC_WS) begin
              res.error_code = ERR_COLON;
              ph_nxt = PH_ERROR;
            end
          end
          PH_VALUE: begin
            unique case (tok.cls) inside
              CC_WS:    ph_nxt = PH_VALUE;
              CC_QUOTE: ph_nxt = PH_STR_FIRST;
              CC_MINUS, CC_ZERO, CC_DIGIT: begin
                res.event_kind = EV_NUM_CHAR;
                res.out_char   = tok.ch;
                ph_nxt = (tok.cls == CC_MINUS) ? PH_NUM_SIGN :
                         (tok.cls == CC_ZERO)  ? PH_NUM_ZERO : PH_NUM_INT;
              end
              CC_DOT, CC_EXP: begin
                res.error_code = ERR_NUMBER;
                ph_nxt = PH_ERROR;
              end
              CC_T: begin
                skip_nxt = BOOL_T_SKIP;
                ph_nxt   = PH_BOOL_T;
              end
              CC_F: begin
                skip_nxt = BOOL_F_SKIP;
                ph_nxt   = PH_BOOL_F;
              end
              default: begin
                res.error_code = ERR_VALUE;
                ph_nxt = PH_ERROR;
              end
            endcase
          end
          PH_BOOL_T, PH_BOOL_F: begin
            if (skip_r > 3'd1) begin
              skip_nxt = skip_r - 1'b1;
            end else begin
              skip_nxt       = '0;
              res.event_kind = EV_BOOL;
              res.bool_value = (ph_main == PH_BOOL_T);
              ph_nxt         = PH_MEMBER;
              pair_nxt       = 1'b1;
            end
          end
          PH_DONE: begin
            if (tok.cls != CC_WS) begin
              res.error_code = ERR_TRAILING;
              ph_nxt = PH_ERROR;
            end
          end
          default: begin
            ph_nxt = PH_ERROR;
          end
        endcase
      end

      if (res.error_code != ERR_NONE) begin
        res.error_position = pos_ext[ERR_POS_W-1:0];
      end

      if (tok.eot && ph_nxt != PH_ERROR) begin
        if (ph_nxt == PH_DONE) begin
          res.event_kind = EV_ACCEPTED;
        end else begin
          res.error_code     = ERR_EARLY_END;
          res.error_position = inc_ext[ERR_POS_W-1:0];
        end
      end
    end

    pos_nxt = pos_inc;
    if (tok.eot) begin
      ph_nxt   = PH_OPEN;
      skip_nxt = '0;
      pair_nxt = 1'b0;
      pos_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_OPEN;
      skip_r <= '0;
      pair_r <= 1'b0;
      pos_r  <= '0;
    end else if (step) begin
      ph_r   <= ph_nxt;
      skip_r <= skip_nxt;
      pair_r <= pair_nxt;
      pos_r  <= pos_nxt;
    end
  end

  `FJP_ASSERT_NOW(a_error_silent, step && ph_r == PH_ERROR, res == '0, "result beat in error phase")
  `FJP_ASSERT_NEXT(a_eot_resets, step && tok.eot, ph_r == PH_OPEN && skip_r == '0 && !pair_r && pos_r == '0, "end of text did not reset")
  `FJP_ASSERT_NEXT(a_error_sticks, step && !tok.eot && res.error_code != ERR_NONE, ph_r == PH_ERROR, "error did not enter error phase")
  `FJP_ASSERT_NOW(a_skip_phase, skip_r != '0, ph_r == PH_KEY_HEX || ph_r == PH_STR_HEX || ph_r == PH_BOOL_T || ph_r == PH_BOOL_F, "skip count outside skip phase")

endmodule
`default_nettype wire
